### src/adc_trimmed_mean_averager_core_defines.svh
// Assertion macros shared by the averager's RTL files.
`ifndef ADC_TRIMMED_MEAN_AVERAGER_CORE_DEFINES_SVH
`define ADC_TRIMMED_MEAN_AVERAGER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ATM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// The condition must never be true outside reset.
`define ATM_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ATM_ASSERT(lbl, prop)
`define ATM_NEVER(lbl, cond)

`endif

`endif

### src/atm_pkg.sv
// Types and constants shared by the averager's modules.
package atm_pkg;

   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 20;
   localparam int COUNT_W  = 8;
   localparam int PHASE_W  = 9;

   localparam int WARMUP_DISCARDS_DEFAULT = 2;

   localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RESET = 8'd8;
   localparam logic [SAMPLE_W-1:0] LOW_SEEN_RESET     = 12'hfff;
   localparam logic [SAMPLE_W-1:0] HIGH_SEEN_RESET    = 12'h000;

   // One finished burst, handed from the front to the divider.
   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] high;
      logic [COUNT_W-1:0]  taken;
   } atm_job_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_OUT  = 4'b1000
   } atm_back_state_type;

endpackage

### src/atm_front.sv
// Front end: takes conversions, skips warm-up, accumulates sum, min and max.
`include "adc_trimmed_mean_averager_core_defines.svh"

module atm_front #(
   parameter int WARMUP_DISCARDS = atm_pkg::WARMUP_DISCARDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_adc_high,
   input  logic [7:0]                    req_adc_low,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [atm_pkg::COUNT_W-1:0]   csr_sample_count,
   output logic                          job_valid,
   input  logic                          job_ready,
   output atm_pkg::atm_job_type          job
);
   import atm_pkg::*;

   localparam logic [PHASE_W-1:0] WARMUP = PHASE_W'(WARMUP_DISCARDS);

   logic [COUNT_W-1:0]  sample_count_ff, sample_count_in;
   logic [PHASE_W-1:0]  phase_count_ff, phase_count_in;
   logic [SUM_W-1:0]    running_sum_ff, running_sum_in;
   logic [SAMPLE_W-1:0] low_seen_ff, low_seen_in;
   logic [SAMPLE_W-1:0] high_seen_ff, high_seen_in;

   logic [SAMPLE_W-1:0] sample;
   logic [SAMPLE_W-1:0] low_new;
   logic [SAMPLE_W-1:0] high_new;
   logic [SUM_W-1:0]    sum_new;
   logic [COUNT_W-1:0]  count_eff;
   logic [PHASE_W-1:0]  taken;
   logic                in_warmup;
   logic                burst_end;
   logic                accept;

   assign csr_ready = 1'b1;
   // The queue always has room when a beat is taken, so a burst end never stalls.
   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sample    = {req_adc_high, req_adc_low[7:4]};
      count_eff = (sample_count_ff == '0) ? COUNT_W'(1) : sample_count_ff;
      in_warmup = phase_count_ff < WARMUP;
      high_new  = (sample > high_seen_ff) ? sample : high_seen_ff;
      low_new   = (sample < low_seen_ff) ? sample : low_seen_ff;
      sum_new   = running_sum_ff + SUM_W'(sample);
      taken     = phase_count_ff + PHASE_W'(1) - WARMUP;
      burst_end = !in_warmup && (taken >= {1'b0, count_eff});

      job_valid = accept && burst_end;
      job.sum   = sum_new;
      job.low   = low_new;
      job.high  = high_new;
      job.taken = taken[COUNT_W-1:0];

      sample_count_in = (csr_valid && csr_ready) ? csr_sample_count : sample_count_ff;
      phase_count_in  = phase_count_ff;
      running_sum_in  = running_sum_ff;
      low_seen_in     = low_seen_ff;
      high_seen_in    = high_seen_ff;
      if (accept) begin
         if (in_warmup) begin
            phase_count_in = phase_count_ff + PHASE_W'(1);
         end else if (burst_end) begin
            phase_count_in = '0;
            running_sum_in = '0;
            low_seen_in    = LOW_SEEN_RESET;
            high_seen_in   = HIGH_SEEN_RESET;
         end else begin
            phase_count_in = phase_count_ff + PHASE_W'(1);
            running_sum_in = sum_new;
            low_seen_in    = low_new;
            high_seen_in   = high_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
         phase_count_ff  <= '0;
         running_sum_ff  <= '0;
         low_seen_ff     <= LOW_SEEN_RESET;
         high_seen_ff    <= HIGH_SEEN_RESET;
      end else begin
         sample_count_ff <= sample_count_in;
         phase_count_ff  <= phase_count_in;
         running_sum_ff  <= running_sum_in;
         low_seen_ff     <= low_seen_in;
         high_seen_ff    <= high_seen_in;
      end
   end

   // A burst never runs past the largest count, so the phase stays bounded.
   `ATM_ASSERT(a_phase_bounded, phase_count_ff < WARMUP + PHASE_W'(255))
   `ATM_NEVER(a_push_when_full, job_valid && !job_ready)

endmodule

### src/atm_queue.sv
// Two-entry queue of finished bursts between the front end and the divider.
`include "adc_trimmed_mean_averager_core_defines.svh"

module atm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  atm_pkg::atm_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output atm_pkg::atm_job_type pop_job
);
   import atm_pkg::*;

   atm_job_type entries_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push;
   logic        do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   `ATM_NEVER(a_fill_over, fill_ff == 2'd3)
   // With one entry held the pointers differ; empty or full they coincide.
   `ATM_ASSERT(a_ptr_fill, (fill_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))

endmodule

### src/atm_back.sv
// Back end: trims min and max when more than two samples were taken, divides by the samples kept, holds the result.
`include "adc_trimmed_mean_averager_core_defines.svh"

module atm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  atm_pkg::atm_job_type          job,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [atm_pkg::SAMPLE_W-1:0]  rsp_average
);
   import atm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   atm_back_state_type  state_ff, state_in;
   atm_job_type         job_ff, job_in;
   logic [SUM_W-1:0]    num_ff, num_in;
   logic [COUNT_W-1:0]  divisor_ff, divisor_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SAMPLE_W-1:0] average_ff, average_in;

   logic [COUNT_W:0]    shifted;
   logic                fits;
   logic                trimmed;

   assign job_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = state_ff == ST_OUT;
   assign rsp_average = average_ff;

   always_comb begin
      shifted = {rem_ff, num_ff[SUM_W-1]};
      fits    = shifted >= {1'b0, divisor_ff};
      trimmed = job_ff.taken > COUNT_W'(2);

      state_in   = state_ff;
      job_in     = job_ff;
      num_in     = num_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      average_in = average_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (trimmed) begin
               num_in     = job_ff.sum - SUM_W'(job_ff.low) - SUM_W'(job_ff.high);
               divisor_in = job_ff.taken - COUNT_W'(2);
            end else begin
               num_in     = job_ff.sum;
               divisor_in = job_ff.taken;
            end
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle shifted into num.
            if (fits) begin
               rem_in = COUNT_W'(shifted - {1'b0, divisor_ff});
            end else begin
               rem_in = shifted[COUNT_W-1:0];
            end
            num_in  = {num_ff[SUM_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               average_in = SAMPLE_W'({num_ff[SUM_W-2:0], fits});
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      num_ff     <= num_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      average_ff <= average_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ATM_ASSERT(a_div_nonzero, (state_ff != ST_DIV) || (divisor_ff != '0))
   `ATM_ASSERT(a_out_then_idle, (rsp_valid && rsp_ready) |=> (state_ff == ST_IDLE))

endmodule

### src/adc_trimmed_mean_averager_core.sv
// After the beat that ends a burst, the back end loads the burst from the queue, trims it,
// runs 20 restoring-divide steps, and holds the result in an output register until taken.
// Throughput: one conversion per cycle while the two-entry burst queue has room; one
// burst per WARMUP_DISCARDS + sample_count conversions; one burst is divided at a time.
// Reset is synchronous: sample_count returns to 8, the burst restarts at warm-up, and
// the queue and divider are emptied.
module adc_trimmed_mean_averager_core #(
   parameter int WARMUP_DISCARDS = atm_pkg::WARMUP_DISCARDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_adc_high,
   input  logic [7:0]                    req_adc_low,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [atm_pkg::SAMPLE_W-1:0]  rsp_average,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [atm_pkg::COUNT_W-1:0]   csr_sample_count
);
   import atm_pkg::*;

   atm_job_type front_job;
   logic        front_valid;
   logic        front_ready;
   atm_job_type back_job;
   logic        back_valid;
   logic        back_ready;

   atm_front #(
      .WARMUP_DISCARDS(WARMUP_DISCARDS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_adc_high    (req_adc_high),
      .req_adc_low     (req_adc_low),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_sample_count(csr_sample_count),
      .job_valid       (front_valid),
      .job_ready       (front_ready),
      .job             (front_job)
   );

   atm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_job  (front_job),
      .pop_valid (back_valid),
      .pop_ready (back_ready),
      .pop_job   (back_job)
   );

   atm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_ready  (back_ready),
      .job        (back_job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_average(rsp_average)
   );

endmodule

### sim/trimmed_mean_checker.sv
// Watches the averager's channels, predicts each burst average and counts mismatches.
module trimmed_mean_checker #(
   parameter int WARMUP_DISCARDS = atm_pkg::WARMUP_DISCARDS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [7:0]                   req_adc_high,
   input  logic [7:0]                   req_adc_low,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [atm_pkg::SAMPLE_W-1:0] rsp_average,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [atm_pkg::COUNT_W-1:0]  csr_sample_count,
   output int unsigned                  pending,
   output int unsigned                  mismatches
);
   import atm_pkg::*;

   logic [COUNT_W-1:0]  count_setting;
   logic [PHASE_W-1:0]  burst_phase;
   logic [SUM_W-1:0]    burst_sum;
   logic [SAMPLE_W-1:0] burst_low;
   logic [SAMPLE_W-1:0] burst_high;

   logic [SAMPLE_W-1:0] averages_due[$];
   logic [SAMPLE_W-1:0] predicted_avg;
   logic [SAMPLE_W-1:0] awaited_avg;
   int unsigned         fail_total;

   function automatic void open_burst();
      burst_phase = '0;
      burst_sum   = '0;
      burst_low   = LOW_SEEN_RESET;
      burst_high  = HIGH_SEEN_RESET;
   endfunction

   // Folds one conversion into the burst; returns 1 when the burst closes with an average.
   function automatic bit fold_conversion(input logic [7:0] hi, input logic [7:0] lo,
                                          output logic [SAMPLE_W-1:0] avg);
      logic [SAMPLE_W-1:0] sample;
      logic [PHASE_W-1:0]  burst_len;
      logic [PHASE_W-1:0]  taken;
      logic [SUM_W-1:0]    quotient;
      sample    = {hi, lo[7:4]};
      burst_len = (count_setting == '0) ? PHASE_W'(1) : PHASE_W'(count_setting);
      avg       = '0;
      if (burst_phase < PHASE_W'(WARMUP_DISCARDS)) begin
         burst_phase = burst_phase + PHASE_W'(1);
         return 1'b0;
      end
      if (sample > burst_high) begin
         burst_high = sample;
      end
      if (sample < burst_low) begin
         burst_low = sample;
      end
      burst_sum   = burst_sum + SUM_W'(sample);
      burst_phase = burst_phase + PHASE_W'(1);
      // A smaller count written mid-burst closes the burst on the next sample.
      taken = burst_phase - PHASE_W'(WARMUP_DISCARDS);
      if (taken < burst_len) begin
         return 1'b0;
      end
      if (taken > PHASE_W'(2)) begin
         quotient = (burst_sum - SUM_W'(burst_low) - SUM_W'(burst_high)) /
                    SUM_W'(taken - PHASE_W'(2));
      end else begin
         quotient = burst_sum / SUM_W'(taken);
      end
      avg = quotient[SAMPLE_W-1:0];
      open_burst();
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         count_setting = SAMPLE_COUNT_RESET;
         open_burst();
         averages_due.delete();
         fail_total = 0;
         pending    <= 0;
         mismatches <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (averages_due.size() == 0) begin
               $display("%0t: unexpected average beat, expected none, got %0d",
                        $time, rsp_average);
               fail_total++;
            end else begin
               awaited_avg = averages_due.pop_front();
               if (rsp_average !== awaited_avg) begin
                  $display("%0t: average mismatch, expected %0d, got %0d",
                           $time, awaited_avg, rsp_average);
                  fail_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            count_setting = csr_sample_count;
         end
         if (req_valid && req_ready) begin
            if (fold_conversion(req_adc_high, req_adc_low, predicted_avg)) begin
               averages_due.push_back(predicted_avg);
            end
         end
         pending    <= averages_due.size();
         mismatches <= fail_total;
      end
   end

endmodule

### sim/tb_adc_trimmed_mean_averager_core.sv
// Drives bursts of conversions and sample-count writes into the averager and gives the verdict.
module tb_adc_trimmed_mean_averager_core;
   import atm_pkg::*;

   localparam int TARGET_CONVERSIONS = 1450;
   localparam int SETTLE_CYCLES      = 40;
   localparam int HOLD_CYCLES        = 300;
   localparam int WATCHDOG_LIMIT     = 3000;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [7:0]          req_adc_high     = '0;
   logic [7:0]          req_adc_low      = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [SAMPLE_W-1:0] rsp_average;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_sample_count = '0;

   int unsigned pending;
   int unsigned mismatches;
   int unsigned conversions_sent = 0;
   int unsigned idle_cycles      = 0;
   int          rsp_hold_cycles  = 0;
   bit          req_eager        = 1'b0;
   bit          rsp_eager        = 1'b0;

   adc_trimmed_mean_averager_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_high     (req_adc_high),
      .req_adc_low      (req_adc_low),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_sample_count (csr_sample_count)
   );

   trimmed_mean_checker average_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_adc_high     (req_adc_high),
      .req_adc_low      (req_adc_low),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_sample_count (csr_sample_count),
      .pending          (pending),
      .mismatches       (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Called at the step of the previous handshake, so valid is either kept high or
   // lowered there, never both.
   task automatic send_conversion(input logic [7:0] hi, input logic [7:0] lo);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_adc_high <= hi;
      req_adc_low  <= lo;
      do @(posedge clock); while (!req_ready);
      conversions_sent++;
   endtask

   // Stops offering beats and waits until every predicted average has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_sample_count(input logic [COUNT_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_sample_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_conversion(input int mode, input logic [7:0] band);
      case (mode)
         3:       return 16'hffff;
         4:       return 16'h0000;
         5:       return {band, 8'($urandom_range(0, 255))};
         default: return 16'($urandom);
      endcase
   endfunction

   // Result side: random stalls per beat, plus one long hold-off when asked for.
   initial begin
      int gap;
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else begin
            gap = rsp_eager ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int           phase;
      int           count_value;
      int           burst_len;
      int           beats;
      int           mode;
      logic [7:0]   band;
      logic [15:0]  conv;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset count of eight: field extremes, and a low nibble that must be ignored.
      send_conversion(8'h00, 8'h00);
      send_conversion(8'hff, 8'hff);
      send_conversion(8'hff, 8'hff);
      send_conversion(8'h00, 8'h00);
      send_conversion(8'h80, 8'h80);
      send_conversion(8'h7f, 8'h7f);
      send_conversion(8'h01, 8'h10);
      send_conversion(8'haa, 8'h55);
      send_conversion(8'h55, 8'haa);
      send_conversion(8'hff, 8'h0f);

      // A count of zero behaves as a count of one.
      write_sample_count(8'd0);
      send_conversion(8'h12, 8'h34);
      send_conversion(8'h56, 8'h78);
      send_conversion(8'hff, 8'hf0);

      // Two samples: plain mean, no trimming.
      write_sample_count(8'd2);
      send_conversion(8'h00, 8'h00);
      send_conversion(8'h00, 8'h00);
      send_conversion(8'hff, 8'hff);
      send_conversion(8'hff, 8'he0);

      // Shrinking the count mid-burst closes the burst on the next sample.
      write_sample_count(8'd10);
      send_conversion(8'h01, 8'h00);
      send_conversion(8'h02, 8'h00);
      send_conversion(8'h10, 8'h20);
      send_conversion(8'h40, 8'h80);
      send_conversion(8'h20, 8'hc0);
      send_conversion(8'hf0, 8'h10);
      send_conversion(8'h33, 8'h30);
      write_sample_count(8'd3);
      send_conversion(8'h05, 8'h50);

      phase = 0;
      while (conversions_sent < TARGET_CONVERSIONS) begin
         case ($urandom_range(0, 9))
            0:       count_value = 0;
            1:       count_value = 1;
            2:       count_value = 2;
            3:       count_value = 3;
            default: count_value = $urandom_range(1, 24);
         endcase
         if (phase == 2 || phase == 12) begin
            count_value = 255;
         end
         mode      = $urandom_range(0, 5);
         band      = 8'($urandom_range(0, 255));
         req_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            // Short bursts against a stalled receiver, so the block backs up.
            count_value = 1;
            req_eager   = 1'b1;
            rsp_eager   = 1'b0;
         end
         if (phase == 2) begin
            mode = 3;
         end
         write_sample_count(COUNT_W'(count_value));
         burst_len = WARMUP_DISCARDS_DEFAULT + ((count_value == 0) ? 1 : count_value);
         beats = burst_len * ((count_value > 40) ? 1 : $urandom_range(1, 4));
         if ($urandom_range(0, 2) == 0) begin
            // Leave a partial burst for the next count write to land in.
            beats += $urandom_range(1, burst_len - 1);
         end
         if (phase == 1) begin
            beats           = 90;
            rsp_hold_cycles = HOLD_CYCLES;
         end
         repeat (beats) begin
            conv = pick_conversion(mode, band);
            send_conversion(conv[15:8], conv[7:0]);
         end
         phase++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
